// ===== design/rws_pkg.sv =====
// rws_pkg: shared types, constants and state codes for the roulette wheel select block
// used by rws_ctrl, rws_datapath and roulette_wheel_select_top
package rws_pkg;

    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_SCORE_BITS = 16;

    localparam int SCORE_IN_W = 16;
    localparam int FRAC_W     = 32;
    localparam int HALF_W     = 16;
    localparam int IDX_W      = 7;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 8;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MUL_LO,
        S_MUL_HI,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic mul_lo;
        logic mul_hi;
        logic scan;
        logic deliver;
    } t_dp_cmd;

    typedef struct packed {
        logic sum_zero;
        logic hit;
        logic at_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== design/rws_ctrl.sv =====
// rws_ctrl: sequencing state machine for load, target scaling, scan and delivery
// depends on rws_pkg for the state enum and the command and status structs
module rws_ctrl
    import rws_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  logic     i_s_tlast,
    output logic     o_s_tready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = S_MUL_LO;
                end
            end
            S_MUL_LO: begin
                if (i_stat.sum_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.at_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_comb begin
        o_s_tready    = (r_state == S_LOAD);
        o_cmd.load    = (r_state == S_LOAD) && i_s_tvalid;
        o_cmd.mul_lo  = (r_state == S_MUL_LO);
        o_cmd.mul_hi  = (r_state == S_MUL_HI);
        o_cmd.scan    = (r_state == S_SCAN);
        o_cmd.deliver = (r_state == S_DONE) && i_stat.out_free;
    end

endmodule

// ===== design/rws_datapath.sv =====
// rws_datapath: score memory, running sum, shared target multiplier, scan and output register
// depends on rws_pkg; driven by commands from rws_ctrl
module rws_datapath
    import rws_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int SCORE_BITS = DEF_SCORE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW    = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W = SCORE_BITS + $clog2(MAX_ITEMS);
    localparam int PRD_W = SUM_W + HALF_W;

    logic [SCORE_BITS-1:0] r_mem [MAX_ITEMS];
    logic [SCORE_BITS-1:0] r_rdata;
    logic [CW-1:0]         r_count;
    logic [SUM_W-1:0]      r_sum;
    logic [FRAC_W-1:0]     r_frac;
    logic [SUM_W-1:0]      r_acc;
    logic [SUM_W-1:0]      r_run;
    logic [AW-1:0]         r_idx;
    logic [CW-1:0]         r_res_idx;
    logic                  r_res_zero;
    logic                  r_out_valid;
    logic [IDX_W-1:0]      r_out_idx;
    logic                  r_out_zero;

    logic [31:0]           w_score_ext;
    logic [SCORE_BITS-1:0] w_score;
    logic                  w_room;
    logic [HALF_W-1:0]     w_mult_b;
    logic [PRD_W-1:0]      w_prod;
    logic [PRD_W:0]        w_prod_sum;
    logic [SUM_W-1:0]      w_run;
    logic [AW-1:0]         w_rd_addr;
    logic [CW+IDX_W-1:0]   w_idx_ext;

    assign w_score_ext = {16'b0, i_s_tdata[SCORE_IN_W-1:0]};
    assign w_score     = w_score_ext[SCORE_BITS-1:0];
    assign w_room      = (r_count < CW'(MAX_ITEMS));
    assign w_mult_b    = i_cmd.mul_hi ? r_frac[FRAC_W-1:HALF_W] : r_frac[HALF_W-1:0];
    assign w_prod      = r_sum * w_mult_b;
    assign w_prod_sum  = {1'b0, w_prod} + (PRD_W + 1)'(r_acc);
    assign w_run       = r_run + SUM_W'(r_rdata);
    assign w_rd_addr   = i_cmd.mul_hi ? '0 : AW'(r_idx + 1'b1);
    assign w_idx_ext   = (CW + IDX_W)'(r_res_idx);

    assign o_stat.sum_zero = (r_sum == '0);
    assign o_stat.hit      = (w_run > r_acc);
    assign o_stat.at_end   = ((CW'(r_idx) + 1'b1) == r_count);
    assign o_stat.out_free = !r_out_valid || i_m_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_zero, r_out_idx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_room) begin
            r_mem[r_count[AW-1:0]] <= w_score;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.deliver) begin
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.load && w_room) begin
            r_count <= r_count + 1'b1;
            r_sum   <= r_sum + SUM_W'(w_score);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_frac <= i_s_tdata[SCORE_IN_W +: FRAC_W];
        end
        if (i_cmd.mul_lo) begin
            r_acc <= w_prod[PRD_W-1:HALF_W];
        end else if (i_cmd.mul_hi) begin
            r_acc <= w_prod_sum[PRD_W-1:HALF_W];
        end
        if (i_cmd.mul_hi) begin
            r_idx <= '0;
            r_run <= '0;
        end else if (i_cmd.scan) begin
            r_idx <= r_idx + 1'b1;
            r_run <= w_run;
        end
        if (i_cmd.mul_lo && o_stat.sum_zero) begin
            r_res_idx  <= '0;
            r_res_zero <= 1'b1;
        end else if (i_cmd.scan) begin
            r_res_zero <= 1'b0;
            if (o_stat.hit) begin
                r_res_idx <= CW'(r_idx);
            end else begin
                r_res_idx <= r_count;
            end
        end
        if (i_cmd.deliver) begin
            r_out_idx  <= w_idx_ext[IDX_W-1:0];
            r_out_zero <= r_res_zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.deliver) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== design/roulette_wheel_select_top.sv =====
// roulette_wheel_select_top: fitness-proportionate selection over a streamed set of scores
// instantiates rws_ctrl and rws_datapath; depends on rws_pkg
//
// usage:
//   slave channel: one word per candidate; tdata carries the score and the Q0.32
//   random fraction, tlast marks the final candidate of the set
//   master channel: one word per set; tdata carries the selected index and the
//   zero-sum flag
//   non-last words are taken one per cycle; scores beyond MAX_ITEMS are dropped
//   after the last word: the fraction is scaled by the sum through one shared
//   multiplier fed one 16-bit half of the fraction at a time, low half then high
//   half; then the scan reads one entry per cycle through the score memory read
//   port (up to the number of stored scores); then the output register is loaded
//   once it is free; a zero-sum set skips the high half and the scan
//   tready is low from the last word until the result enters the output register
//   a stalled receiver holds the result; loading of the next set goes on, and the
//   next result waits until the output register frees up
//   reset (synchronous, active low) empties the set and drops any pending result;
//   the score memory needs no clearing
module roulette_wheel_select_top
    import rws_pkg::*;
#(
    parameter int MAX_ITEMS  = DEF_MAX_ITEMS,
    parameter int SCORE_BITS = DEF_SCORE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,  // score[15:0], random_fraction[47:16]
    input  logic                  i_s_tlast,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata   // selected_index[6:0], zero_sum[7]
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    rws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rws_datapath #(
        .MAX_ITEMS  (MAX_ITEMS),
        .SCORE_BITS (SCORE_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat)
    );

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.deliver |-> (!o_m_tvalid || i_m_tready))
        else $error("pending result overwritten");

    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> !o_s_tready)
        else $error("input taken during selection");

    a_zero_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[7]) |-> (o_m_tdata[6:0] == 7'd0))
        else $error("zero sum with nonzero index");

    a_scan_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan |-> !o_s_tready)
        else $error("scan while loading");
`endif

endmodule

// ===== sim/tb.sv =====
// tb: self-checking bench for roulette_wheel_select_top, streams scored candidate sets
// and checks each selected index against a local prediction; depends on rws_pkg
`timescale 1ns / 1ps

module tb;
    import rws_pkg::*;

    localparam int WHEEL_SLOTS = DEF_MAX_ITEMS;
    localparam int SLOT_AW     = $clog2(WHEEL_SLOTS);
    localparam int TOTAL_ITEMS = 600;
    localparam int CALM_ITEMS  = 80;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYC  = 100;

    typedef enum int {SC_RANDOM, SC_ZERO, SC_MAX, SC_TINY, SC_SPARSE} t_score_style;
    typedef enum int {FR_RANDOM, FR_ZERO, FR_FULL, FR_LOW, FR_HIGH} t_frac_style;

    typedef struct {
        bit [SCORE_IN_W-1:0] score;
        bit [FRAC_W-1:0]     frac;
        bit                  last;
        bit                  wait_drain;
        bit                  hold_sink;
        bit                  calm;
    } t_cand_word;

    typedef struct {
        bit [IDX_W-1:0] slot;
        bit             zero_total;
    } t_pick;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    logic sink_hold_req = 1'b0;
    logic calm_phase = 1'b0;

    t_cand_word pending_words[$];
    t_pick      expected_picks[$];
    t_cand_word in_flight;

    bit [SCORE_IN_W-1:0] wheel_scores[WHEEL_SLOTS];
    bit [IDX_W-1:0]      wheel_fill = '0;
    bit [21:0]           wheel_total = '0;

    int  mismatch_count = 0;
    int  words_queued = 0;
    int  quiet_cycles = 0;
    int  src_gap = 0;
    bit  src_lazy = 1'b0;
    int  sink_gap = 0;
    bit  sink_lazy = 1'b0;
    int  hold_cnt = 0;
    bit  sink_hold_ack = 1'b0;
    bit  mark_drain = 1'b0;
    bit  mark_hold = 1'b0;

    roulette_wheel_select_top uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // score[15:0], random_fraction[47:16]
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)    // selected_index[6:0], zero_sum[7]
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // store the score, and on the closing word spin the wheel
    task automatic accept_candidate(input t_cand_word w);
        bit [63:0] target;
        bit [63:0] running;
        int        slot;
        t_pick     p;
        if (wheel_fill < WHEEL_SLOTS) begin
            wheel_scores[wheel_fill[SLOT_AW-1:0]] = w.score;
            wheel_total = wheel_total + w.score;
            wheel_fill = wheel_fill + 1'b1;
        end
        if (w.last) begin
            p.zero_total = (wheel_total == 0);
            slot = 0;
            if (!p.zero_total) begin
                target = (64'(wheel_total) * 64'(w.frac)) >> FRAC_W;
                running = 0;
                for (slot = 0; slot < wheel_fill; slot++) begin
                    running = running + wheel_scores[slot[SLOT_AW-1:0]];
                    if (running > target) break;
                end
            end
            p.slot = slot[IDX_W-1:0];
            expected_picks = {expected_picks, p};
            wheel_fill = '0;
            wheel_total = '0;
        end
    endtask

    task automatic add_word(input bit [SCORE_IN_W-1:0] score, input bit [FRAC_W-1:0] frac,
                            input bit last);
        t_cand_word w;
        w.score = score;
        w.frac = frac;
        w.last = last;
        w.wait_drain = mark_drain;
        w.hold_sink = mark_hold;
        w.calm = (words_queued >= TOTAL_ITEMS - CALM_ITEMS);
        mark_drain = 1'b0;
        mark_hold = 1'b0;
        pending_words = {pending_words, w};
        words_queued++;
    endtask

    function automatic bit [SCORE_IN_W-1:0] pick_score(input t_score_style st);
        case (st)
            SC_ZERO:   return '0;
            SC_MAX:    return '1;
            SC_TINY:   return SCORE_IN_W'($urandom_range(0, 3));
            SC_SPARSE: return ($urandom_range(0, 5) == 0) ? SCORE_IN_W'($urandom) : '0;
            default:   return SCORE_IN_W'($urandom);
        endcase
    endfunction

    function automatic bit [FRAC_W-1:0] pick_frac(input t_frac_style st);
        case (st)
            FR_ZERO: return '0;
            FR_FULL: return '1;
            FR_LOW:  return FRAC_W'($urandom_range(0, 255));
            FR_HIGH: return ~FRAC_W'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_set(input int len, input t_score_style sst, input t_frac_style fst);
        for (int i = 0; i < len; i++)
            add_word(pick_score(sst), pick_frac(fst), i == len - 1);
    endtask

    // source side
    always @(posedge i_clk) begin
        t_cand_word w;
        logic       nxt_valid;
        logic       took;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
        end else begin
            took = s_tvalid && s_tready;
            if (took)
                accept_candidate(in_flight);
            if (took || !s_tvalid) begin
                nxt_valid = 1'b0;
                if ($urandom_range(0, 39) == 0)
                    src_lazy = !src_lazy;
                if (src_gap > 0) begin
                    src_gap--;
                end else if (!calm_phase && src_lazy && $urandom_range(0, 2) == 0) begin
                    src_gap = $urandom_range(0, 6);
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].wait_drain && expected_picks.size() != 0)) begin
                    w = pending_words.pop_front();
                    in_flight = w;
                    nxt_valid = 1'b1;
                    s_tdata <= {w.frac, w.score};
                    s_tlast <= w.last;
                    if (w.hold_sink)
                        sink_hold_req <= !sink_hold_req;
                    if (w.calm)
                        calm_phase <= 1'b1;
                end
                s_tvalid <= nxt_valid;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        logic  rdy;
        t_pick want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch("unexpected result, index", m_tdata[IDX_W-1:0], -1);
                end else begin
                    want = expected_picks.pop_front();
                    if (m_tdata[IDX_W-1:0] != want.slot)
                        report_mismatch("selected_index", m_tdata[IDX_W-1:0], want.slot);
                    if (m_tdata[IDX_W] != want.zero_total)
                        report_mismatch("zero_sum", m_tdata[IDX_W], want.zero_total);
                end
            end
            if ($urandom_range(0, 39) == 0)
                sink_lazy = !sink_lazy;
            rdy = 1'b1;
            if (hold_cnt > 0) begin
                hold_cnt--;
                rdy = 1'b0;
            end else if (sink_hold_req != sink_hold_ack) begin
                sink_hold_ack = sink_hold_req;
                hold_cnt = HOLD_CYCLES - 1;
                rdy = 1'b0;
            end else if (calm_phase) begin
                rdy = 1'b1;
            end else if (sink_gap > 0) begin
                sink_gap--;
                rdy = 1'b0;
            end else if (sink_lazy && $urandom_range(0, 2) == 0) begin
                sink_gap = $urandom_range(0, 6);
                rdy = 1'b0;
            end
            m_tready <= rdy;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int set_no;
        int len;
        t_score_style sst;
        t_frac_style  fst;

        // single zero score
        add_word(16'h0000, 32'h1234_5678, 1'b1);
        // single max score, max fraction
        add_word(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
        // leading zeros, zero fraction
        add_word(16'h0000, 32'h0, 1'b0);
        add_word(16'h0000, 32'h0, 1'b0);
        add_word(16'h0000, 32'h0, 1'b0);
        add_word(16'h0005, 32'h0, 1'b1);
        // two equal weights at both fraction extremes
        add_word(16'h0001, 32'h0, 1'b0);
        add_word(16'h0001, 32'h0, 1'b1);
        add_word(16'h0001, 32'h0, 1'b0);
        add_word(16'h0001, 32'hFFFF_FFFF, 1'b1);
        // running total equals target exactly at the middle slot
        add_word(16'hFFFF, 32'h0, 1'b0);
        add_word(16'h0000, 32'h0, 1'b0);
        add_word(16'hFFFF, 32'h8000_0000, 1'b1);
        // all zero, several entries
        add_word(16'h0000, 32'h0, 1'b0);
        add_word(16'h0000, 32'h0, 1'b0);
        add_word(16'h0000, 32'hFFFF_FFFF, 1'b1);
        // mixed bit patterns
        add_word(16'h0001, 32'h0, 1'b0);
        add_word(16'h0002, 32'h0, 1'b0);
        add_word(16'hAAAA, 32'h0, 1'b0);
        add_word(16'h5555, 32'h5555_5555, 1'b1);

        set_no = 0;
        while (words_queued < TOTAL_ITEMS) begin
            sst = t_score_style'($urandom_range(0, 4));
            fst = t_frac_style'($urandom_range(0, 4));
            if (set_no == 2) begin
                len = WHEEL_SLOTS;
                sst = SC_MAX;
            end else if (set_no == 5) begin
                len = WHEEL_SLOTS + 6;
            end else if ($urandom_range(0, 24) == 0) begin
                len = $urandom_range(WHEEL_SLOTS - 4, WHEEL_SLOTS + 6);
            end else begin
                len = $urandom_range(1, 12);
            end
            if (set_no == 15)
                mark_drain = 1'b1;
            if (set_no == 25)
                mark_hold = 1'b1;
            add_set(len, sst, fst);
            set_no++;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || s_tvalid || expected_picks.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        if (expected_picks.size() != 0)
            report_mismatch("results left waiting", expected_picks.size(), 0);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
